/* sv/mrbd_pkg.sv */
// shared types and constants for the marker run-length byte decoder
// no dependencies; imported by mrbd_ctrl, mrbd_datapath and the top level
package mrbd_pkg;

  localparam logic [7:0] MARKER_RESET = 8'h42;
  localparam int unsigned HDR_BYTES = 4;
  localparam int unsigned OUT_DATA_W = 72;

  typedef enum logic [4:0] {
    ST_HDR    = 5'b00001,
    ST_TOKEN  = 5'b00010,
    ST_SYMBOL = 5'b00100,
    ST_COUNT  = 5'b01000,
    ST_EMIT   = 5'b10000
  } mrbd_state_t;

  typedef struct packed {
    logic hdr_shift;
    logic hdr_load;
    logic load_lit;
    logic load_sym;
    logic load_cnt;
    logic emit;
  } mrbd_cmd_t;

  typedef struct packed {
    logic is_marker;
    logic len_zero;
    logic run_last;
    logic block_end;
  } mrbd_stat_t;

endpackage

/* sv/mrbd_ctrl.sv */
// parse controller: header, token, symbol, count and emit states
// depends on mrbd_pkg; drives mrbd_datapath through mrbd_cmd_t
module mrbd_ctrl
  import mrbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  mrbd_stat_t stat,
  output mrbd_cmd_t  cmd
);

  mrbd_state_t state_r, state_nxt;
  logic [1:0]  hdr_idx_r, hdr_idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        in_acc;
  logic        slot_free;

  assign in_tready  = (state_r != ST_EMIT);
  assign in_acc     = in_tvalid && in_tready;
  assign slot_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    hdr_idx_nxt = hdr_idx_r;
    cmd         = '0;
    unique case (state_r)
      ST_HDR: begin
        if (in_acc) begin
          cmd.hdr_shift = 1'b1;
          if (hdr_idx_r == 2'(HDR_BYTES - 1)) begin
            cmd.hdr_load = 1'b1;
            hdr_idx_nxt  = '0;
            state_nxt    = stat.len_zero ? ST_HDR : ST_TOKEN;
          end else begin
            hdr_idx_nxt = hdr_idx_r + 2'd1;
          end
        end
      end
      ST_TOKEN: begin
        if (in_acc) begin
          if (stat.is_marker) begin
            state_nxt = ST_SYMBOL;
          end else begin
            cmd.load_lit = 1'b1;
            state_nxt    = ST_EMIT;
          end
        end
      end
      ST_SYMBOL: begin
        if (in_acc) begin
          cmd.load_sym = 1'b1;
          state_nxt    = ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (in_acc) begin
          cmd.load_cnt = 1'b1;
          state_nxt    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd.emit = 1'b1;
          if (stat.run_last) state_nxt = stat.block_end ? ST_HDR : ST_TOKEN;
        end
      end
      default: state_nxt = ST_HDR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (cmd.emit)   out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_HDR;
      hdr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hdr_idx_r   <= hdr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* sv/mrbd_datapath.sv */
// datapath: marker register, header shift, block and run counters, output word
// depends on mrbd_pkg; commanded by mrbd_ctrl
module mrbd_datapath
  import mrbd_pkg::*;
#(
  parameter int unsigned OUT_LANES   = 8,
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            in_byte,
  input  logic                  cfg_wr,
  input  logic [7:0]            cfg_byte,
  input  mrbd_cmd_t             cmd,
  output mrbd_stat_t            stat,
  output logic [OUT_DATA_W-1:0] out_data
);

  localparam int unsigned CW = (LENGTH_BITS > 9) ? LENGTH_BITS : 9;
  localparam logic [3:0]  LANES4 = 4'(OUT_LANES);

  logic [7:0]             marker_r;
  logic [31:0]            len_shift_r;
  logic [31:0]            len_shift_nxt;
  logic [LENGTH_BITS-1:0] bytes_left_r;
  logic [8:0]             run_left_r;
  logic [7:0]             symbol_r;
  logic [OUT_DATA_W-1:0]  out_data_r;

  logic [8:0]             run_req;
  logic [CW-1:0]          req_ext;
  logic [CW-1:0]          left_ext;
  logic [8:0]             run_load;
  logic [3:0]             cnt;
  logic [63:0]            word;

  assign len_shift_nxt  = {in_byte, len_shift_r[31:8]};
  assign stat.len_zero  = (len_shift_nxt[LENGTH_BITS-1:0] == '0);
  assign stat.is_marker = (in_byte == marker_r);

  // requested run length, cut at what the block still owes
  assign run_req  = cmd.load_lit ? 9'd1 : ((in_byte == 8'd0) ? 9'd256 : {1'b0, in_byte});
  assign req_ext  = CW'(run_req);
  assign left_ext = CW'(bytes_left_r);
  assign run_load = (left_ext < req_ext) ? left_ext[8:0] : run_req;

  assign stat.run_last  = (run_left_r <= 9'(OUT_LANES));
  assign cnt            = stat.run_last ? run_left_r[3:0] : LANES4;
  assign stat.block_end = (bytes_left_r == LENGTH_BITS'(cnt));

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      word[8*i +: 8] = (4'(i) < cnt) ? symbol_r : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r     <= MARKER_RESET;
      bytes_left_r <= '0;
    end else begin
      if (cfg_wr) marker_r <= cfg_byte;
      if (cmd.hdr_load) bytes_left_r <= len_shift_nxt[LENGTH_BITS-1:0];
      else if (cmd.emit) bytes_left_r <= bytes_left_r - LENGTH_BITS'(cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hdr_shift) len_shift_r <= len_shift_nxt;
    if (cmd.load_sym)  symbol_r <= in_byte;
    if (cmd.load_lit)  symbol_r <= in_byte;
    if (cmd.load_lit || cmd.load_cnt) run_left_r <= run_load;
    else if (cmd.emit) run_left_r <= run_left_r - 9'(cnt);
    if (cmd.emit) out_data_r <= {2'b00, stat.block_end, stat.run_last, cnt, word};
  end

  assign out_data = out_data_r;

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> run_left_r != 9'd0)
    else $error("word emitted with empty run");

  a_run_within_block: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> CW'(run_left_r) <= CW'(bytes_left_r))
    else $error("run exceeds block remainder");

  a_last_word_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && stat.run_last) |=> run_left_r == 9'd0)
    else $error("run counter not drained after last word");

endmodule

/* sv/marker_rle_byte_decoder.sv */
// top level of the marker run-length byte decoder
// depends on mrbd_pkg, mrbd_ctrl and mrbd_datapath
//
// Decodes a byte stream of blocks, each opened by a 4-beat little-endian
// output length, then tokens: a byte equal to the escape marker is followed
// by a symbol beat and a count beat (count 0 means 256), any other byte is a
// single literal. Decoded bytes leave as words of up to OUT_LANES copies of
// one symbol, cut at the block length; after the block's last byte the next
// input beat opens a new header. Header, marker and symbol beats only move
// the parser on; a literal is accepted, then leaves as one output word; a
// count beat is accepted, then its run (n bytes after truncation) leaves as
// ceil(n / OUT_LANES) words, loaded into the single output register one word
// per cycle while the receiver keeps it free; input is held while a run
// expands. The input side reopens as soon as the last word of a run sits in
// the output register, so the next beat can be taken while that word waits.
module marker_rle_byte_decoder
  import mrbd_pkg::*;
#(
  parameter int unsigned OUT_LANES   = 8,
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // escape marker write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_data,    // [7:0] escape_marker
  // compressed byte stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,    // [7:0] coded_byte
  // decoded words
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata    // [63:0] out_bytes, [67:64] byte_count,
                                             // [68] run_done, [69] block_done, [71:70] zero
);

  mrbd_cmd_t  cmd;
  mrbd_stat_t stat;

  // marker register is always writable; the user must write it only while idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  mrbd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  mrbd_datapath #(
    .OUT_LANES   (OUT_LANES),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_byte  (in_tdata),
    .cfg_wr   (cfg_valid && cfg_ready),
    .cfg_byte (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_tdata)
  );

endmodule

/* bench/marker_rle_byte_decoder_tb.sv */
// self-checking testbench for marker_rle_byte_decoder, top module marker_rle_byte_decoder_tb
// depends on mrbd_pkg and the marker_rle_byte_decoder rtl; nothing else is read
module marker_rle_byte_decoder_tb;
  import mrbd_pkg::*;

  localparam int unsigned LANES        = 8;
  localparam int unsigned LEN_BITS     = 32;
  localparam int          RANDOM_ITEMS = 100;
  localparam int          CYCLE_LIMIT  = 2000000;
  localparam int          SETTLE_CYCLES = 4;

  // where the decoder is in the byte stream
  typedef enum int {
    PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3, PH_TOKEN, PH_SYMBOL, PH_COUNT
  } parse_phase_t;

  // one decoded output word as the block should present it
  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  count;
    logic        run_done;
    logic        block_done;
  } decoded_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [7:0]            cfg_data;     // [7:0] escape_marker
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;     // [7:0] coded_byte
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;    // [63:0] out_bytes, [67:64] byte_count,
                                       // [68] run_done, [69] block_done

  // decoder state mirrored by the bench
  parse_phase_t  dec_phase;
  logic [31:0]   dec_shift;
  logic [31:0]   dec_left;
  logic [7:0]    dec_symbol;
  logic [7:0]    dec_marker;
  decoded_word_t pending_words[$];

  int err_cnt    = 0;
  int bytes_sent = 0;
  int cycle_cnt  = 0;
  int tx_max_gap = 18;
  int rx_max_gap = 18;
  int rx_hold    = 0;   // long receiver stall, counted down by the receiver

  marker_rle_byte_decoder #(
    .OUT_LANES  (LANES),
    .LENGTH_BITS(LEN_BITS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog against a hung handshake
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // expand n copies of sym into words of up to LANES bytes, cut at block end
  function automatic void expand_run(input logic [7:0] sym, input logic [31:0] n);
    logic [31:0]   remain;
    logic [31:0]   chunk;
    decoded_word_t w;
    remain = (n > dec_left) ? dec_left : n;
    while (remain != 0) begin
      chunk = (remain < LANES) ? remain : LANES;
      w.bytes = '0;
      for (int i = 0; i < chunk; i++) w.bytes[8*i +: 8] = sym;
      remain       = remain - chunk;
      dec_left     = dec_left - chunk;
      w.count      = chunk[3:0];
      w.run_done   = (remain == 0);
      w.block_done = (dec_left == 0);
      pending_words.push_back(w);
    end
    dec_phase = (dec_left == 0) ? PH_HDR0 : PH_TOKEN;
  endfunction

  // advance the mirrored decoder by one accepted byte
  function automatic void predict_byte(input logic [7:0] b);
    logic [31:0] len_mask;
    len_mask = 32'hFFFF_FFFF >> (32 - LEN_BITS);
    case (dec_phase)
      PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3: begin
        // little-endian length: each byte enters at the top
        dec_shift = {b, dec_shift[31:8]};
        if (dec_phase == PH_HDR3) begin
          dec_left  = dec_shift & len_mask;
          dec_shift = '0;
          dec_phase = (dec_left == 0) ? PH_HDR0 : PH_TOKEN;
        end else begin
          dec_phase = parse_phase_t'(dec_phase + 1);
        end
      end
      PH_TOKEN: begin
        if (b == dec_marker) dec_phase = PH_SYMBOL;
        else expand_run(b, 32'd1);
      end
      PH_SYMBOL: begin
        dec_symbol = b;
        dec_phase  = PH_COUNT;
      end
      default: begin
        // count 0 stands for a full 256-byte run
        expand_run(dec_symbol, (b == 8'd0) ? 32'd256 : {24'd0, b});
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  function automatic void check_word(input logic [OUT_DATA_W-1:0] d);
    decoded_word_t exp_w;
    if (pending_words.size() == 0) begin
      $error("unexpected output word %h", d);
      err_cnt++;
    end else begin
      exp_w = pending_words.pop_front();
      if (d[63:0] !== exp_w.bytes) begin
        $error("out_bytes: expected %h, actual %h", exp_w.bytes, d[63:0]);
        err_cnt++;
      end
      if (d[67:64] !== exp_w.count) begin
        $error("byte_count: expected %0d, actual %0d", exp_w.count, d[67:64]);
        err_cnt++;
      end
      if (d[68] !== exp_w.run_done) begin
        $error("run_done: expected %b, actual %b", exp_w.run_done, d[68]);
        err_cnt++;
      end
      if (d[69] !== exp_w.block_done) begin
        $error("block_done: expected %b, actual %b", exp_w.block_done, d[69]);
        err_cnt++;
      end
    end
  endfunction

  // receiver: random stall after each word, plus an occasional long hold-off
  initial begin
    int rx_wait;
    rx_wait = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (out_tvalid && out_tready) begin
          check_word(out_tdata);
          rx_wait = $urandom_range(0, rx_max_gap);
        end
        if (rx_hold > 0) begin
          rx_hold--;
          out_tready <= 1'b0;
        end else if (rx_wait > 0) begin
          rx_wait--;
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // offer one byte after a random gap; tvalid stays high after the beat
  // so a back-to-back byte does not drop it
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_byte(b);
    bytes_sent++;
  endtask

  task automatic send_header(input logic [31:0] len);
    for (int i = 0; i < 4; i++) send_byte(len[8*i +: 8]);
  endtask

  // sender pauses until every word is out, then lets the block settle
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called while the decoder is idle
  task automatic write_marker(input logic [7:0] m);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    dec_marker = m;
  endtask

  function automatic logic [7:0] draw_repeat();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'd0;
    if (r < 70) return 8'($urandom_range(1, 16));
    return 8'($urandom_range(17, 255));
  endfunction

  function automatic logic [31:0] draw_block_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return 32'd0;
    if (r < 75) return 32'($urandom_range(1, 48));
    if (r < 95) return 32'($urandom_range(49, 300));
    return 32'($urandom_range(301, 520));
  endfunction

  function automatic int draw_gap_limit();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 4;
      default: return 18;
    endcase
  endfunction

  // one token that fits the current decoder phase: mostly well-formed
  // literals and runs, some raw noise bytes that may open a triple
  task automatic send_token();
    int         pick;
    logic [7:0] b;
    if (dec_phase == PH_TOKEN) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        b = 8'($urandom);
        while (b == dec_marker) b = 8'($urandom);
        send_byte(b);
      end else if (pick < 88) begin
        send_byte(dec_marker);
        send_byte(8'($urandom));
        send_byte(draw_repeat());
      end else begin
        send_byte(8'($urandom));
      end
    end else begin
      // finish a triple opened by noise
      send_byte(8'($urandom));
    end
  endtask

  // a whole block: header, then tokens until the length is used up
  task automatic send_block();
    send_header(draw_block_len());
    while (dec_phase != PH_HDR0) send_token();
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // literals at both extremes, a one-byte run whose symbol equals the
  // marker and a run that spills into a second word, at the reset marker
  task automatic test_token_kinds();
    send_header(32'd12);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(MARKER_RESET);
    send_byte(MARKER_RESET);
    send_byte(8'd1);
    send_byte(MARKER_RESET);
    send_byte(8'h3C);
    send_byte(8'd9);
  endtask

  // zero-length block, a run cut at the block end, and a count of zero
  // expanding to 256 bytes as the longest possible burst of words
  task automatic test_block_edges();
    send_header(32'd0);
    send_header(32'd5);
    send_byte(MARKER_RESET);
    send_byte(8'h5A);
    send_byte(8'd200);
    send_header(32'd256);
    send_byte(MARKER_RESET);
    send_byte(8'hC3);
    send_byte(8'd0);
  endtask

  // marker at both extremes and back to its reset value
  task automatic test_marker_settings();
    logic [7:0] markers[3];
    markers = '{8'h00, 8'hFF, MARKER_RESET};
    foreach (markers[i]) begin
      wait_drained();
      write_marker(markers[i]);
      repeat (3) send_block();
    end
  endtask

  // receiver stalls for a long stretch while bytes keep coming, so the
  // output register fills and the input side has to push back
  task automatic test_backpressure();
    wait_drained();
    tx_max_gap = 0;
    rx_hold    = 400;
    send_header(32'd150);
    for (int i = 0; i < 4; i++) begin
      send_byte(dec_marker);
      send_byte(8'($urandom));
      send_byte(8'd40);
    end
    wait_drained();
    tx_max_gap = 18;
  endtask

  // long random stream of blocks; marker and idle rates change on the way
  task automatic test_random_stream();
    int start;
    int last_cfg;
    start    = bytes_sent;
    last_cfg = bytes_sent;
    while (bytes_sent - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        tx_max_gap = draw_gap_limit();
        rx_max_gap = draw_gap_limit();
      end
      if (bytes_sent - last_cfg > 90) begin
        wait_drained();
        write_marker(8'($urandom));
        last_cfg = bytes_sent;
      end
      send_block();
    end
    tx_max_gap = 18;
    rx_max_gap = 18;
  endtask

  // header with the top bytes set: at full length width nothing is masked,
  // the block never ends, so this runs last
  task automatic test_wide_header();
    wait_drained();
    send_header(32'h8001_00FF);
    repeat (12) send_token();
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    dec_phase  = PH_HDR0;
    dec_shift  = '0;
    dec_left   = '0;
    dec_symbol = '0;
    dec_marker = MARKER_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_token_kinds();
    test_block_edges();
    test_marker_settings();
    test_backpressure();
    test_random_stream();
    test_wide_header();

    // stray words after the last expected one still count as failures
    wait_drained();
    repeat (40) @(posedge clk);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
